### rtl/nlt_pkg.sv
// Package for the node liveness tracker: table entry and result types,
// operation, status, result and register codes. No dependencies.
package nlt_pkg;

    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_BEAT   = 3'd1;
    localparam logic [2:0] OP_JOIN   = 3'd2;
    localparam logic [2:0] OP_DEAD   = 3'd3;
    localparam logic [2:0] OP_ADD    = 3'd4;
    localparam logic [2:0] OP_QUERY  = 3'd5;

    localparam logic [2:0] ST_UNKNOWN  = 3'd0;
    localparam logic [2:0] ST_READY    = 3'd2;
    localparam logic [2:0] ST_BUSY     = 3'd3;
    localparam logic [2:0] ST_DEGRADED = 3'd4;
    localparam logic [2:0] ST_DEAD     = 3'd5;

    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_DIED   = 2'd1;
    localparam logic [1:0] KIND_RETRY  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] CFG_BEAT  = 2'd0;
    localparam logic [1:0] CFG_MISS  = 2'd1;
    localparam logic [1:0] CFG_RETRY = 2'd2;
    localparam logic [1:0] CFG_OWN   = 2'd3;

    localparam logic [15:0] BEAT_RESET  = 16'd1000;
    localparam logic [7:0]  MISS_RESET  = 8'd3;
    localparam logic [23:0] RETRY_RESET = 24'd5000;
    localparam logic [15:0] BEAT_FLOOR  = 16'd50;

    typedef struct packed {
        logic [2:0]  status;
        logic        seen;
        logic [31:0] seen_ms;
        logic [7:0]  miss;
        logic [15:0] active;
        logic        link;
        logic        pending;
        logic [31:0] dead_time;
    } t_entry;

    typedef struct packed {
        logic [5:0]  node;
        logic [1:0]  kind;
        logic [2:0]  status;
        logic [15:0] active;
        logic [7:0]  miss;
        logic        link;
    } t_result;

endpackage

### rtl/nlt_table.sv
// Node table memory: one write port and one read port with registered data.
// Depends on nlt_pkg for the entry type.
module nlt_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  nlt_pkg::t_entry i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output nlt_pkg::t_entry o_rdata
);

    nlt_pkg::t_entry r_mem [DEPTH];
    nlt_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/node_liveness_tracker.sv
// Node liveness tracker top level: control, configuration and scans.
// Depends on nlt_pkg and nlt_table.
//
//   channel  direction  handshake                  payload
//   in       to block   i_in_valid / o_in_ready    operation, node, time, counts
//   out      from block o_out_valid / i_out_ready  node, kind, status, counts, last
//   cfg      to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A node operation is a table read, then the write back.
// A tick or query scan reads one table entry per cycle while the output does not stall it.
// After reset a clearing pass writes every table entry before the first item.
// A stalled output holds the scan at the entry that found the next result.
module node_liveness_tracker #(
    parameter int NODES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_node_id,
    input  logic [31:0] i_now_ms,
    input  logic        i_has_payload,
    input  logic [15:0] i_reported_active,
    input  logic signed [15:0] i_active_delta,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [5:0]  o_result_node,
    output logic [1:0]  o_result_kind,
    output logic [2:0]  o_node_status,
    output logic [15:0] o_active_count,
    output logic [7:0]  o_miss_count,
    output logic        o_link_flag,
    output logic        o_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CW = (IW > 6) ? IW : 6;
    localparam logic [IW-1:0] LAST_IDX = IW'(NODES - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_OP    = 5'b00100,
        S_SCAN  = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;

    logic [15:0] r_beat;
    logic [7:0]  r_miss_limit;
    logic [23:0] r_retry;
    logic [5:0]  r_own;
    logic [23:0] r_window;

    logic [2:0]  r_op;
    logic [IW-1:0] r_node;
    logic [31:0] r_now;
    logic        r_has_payload;
    logic [15:0] r_reported;
    logic signed [15:0] r_delta;

    nlt_pkg::t_result r_out, n_out;
    logic r_out_valid, n_out_valid;
    logic r_out_last, n_out_last;
    nlt_pkg::t_result r_hold, n_hold;
    logic r_hold_valid, n_hold_valid;

    logic            we, re;
    logic [IW-1:0]   waddr, raddr;
    nlt_pkg::t_entry wdata, rdata;

    nlt_table #(.DEPTH(NODES), .AW(IW)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    logic [15:0] iv;
    logic [7:0]  ml;
    assign iv = (r_beat < nlt_pkg::BEAT_FLOOR) ? nlt_pkg::BEAT_FLOOR : r_beat;
    assign ml = (r_miss_limit == 8'd0) ? 8'd1 : r_miss_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat       <= nlt_pkg::BEAT_RESET;
            r_miss_limit <= nlt_pkg::MISS_RESET;
            r_retry      <= nlt_pkg::RETRY_RESET;
            r_own        <= 6'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                nlt_pkg::CFG_BEAT:  r_beat <= i_cfg_data[15:0];
                nlt_pkg::CFG_MISS:  r_miss_limit <= i_cfg_data[7:0];
                nlt_pkg::CFG_RETRY: r_retry <= i_cfg_data;
                nlt_pkg::CFG_OWN:   r_own <= i_cfg_data[5:0];
                default: ;
            endcase
        end
        r_window <= iv * ml;
    end

    logic in_acc, out_free;
    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    logic node_ok, is_scan, is_node_op;
    assign node_ok = int'(i_node_id) < NODES;
    assign is_scan = (i_operation == nlt_pkg::OP_TICK) || (i_operation == nlt_pkg::OP_QUERY);
    assign is_node_op = node_ok && (i_operation >= nlt_pkg::OP_BEAT) &&
                        (i_operation <= nlt_pkg::OP_ADD);

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op          <= i_operation;
            r_node        <= IW'(i_node_id);
            r_now         <= i_now_ms;
            r_has_payload <= i_has_payload;
            r_reported    <= i_reported_active;
            r_delta       <= i_active_delta;
        end
    end

    // Node operation update.
    nlt_pkg::t_entry op_e;
    logic signed [17:0] add_sum;
    always_comb begin
        op_e = rdata;
        add_sum = $signed({2'b00, rdata.active}) + 18'(r_delta);
        case (r_op)
            nlt_pkg::OP_BEAT: begin
                op_e.seen_ms   = r_now;
                op_e.seen      = 1'b1;
                op_e.miss      = 8'd0;
                op_e.pending   = 1'b0;
                if (rdata.status != nlt_pkg::ST_BUSY) begin
                    op_e.status = nlt_pkg::ST_READY;
                end
                if (r_has_payload) begin
                    op_e.active = r_reported;
                end
            end
            nlt_pkg::OP_JOIN: begin
                op_e.status    = nlt_pkg::ST_READY;
                op_e.link      = 1'b1;
                op_e.miss      = 8'd0;
                op_e.seen_ms   = r_now;
                op_e.seen      = 1'b1;
                op_e.pending   = 1'b0;
            end
            nlt_pkg::OP_DEAD: begin
                op_e.status    = nlt_pkg::ST_DEAD;
                op_e.link      = 1'b0;
                op_e.active    = 16'd0;
                op_e.pending   = 1'b1;
                op_e.dead_time = r_now;
            end
            default: begin
                if (add_sum < 0) begin
                    op_e.active = 16'd0;
                end else if (add_sum > 18'sd65535) begin
                    op_e.active = 16'hFFFF;
                end else begin
                    op_e.active = add_sum[15:0];
                end
            end
        endcase
        if ((r_op == nlt_pkg::OP_ADD) || ((r_op == nlt_pkg::OP_BEAT) && r_has_payload)) begin
            if (op_e.status == nlt_pkg::ST_READY && op_e.active != 16'd0) begin
                op_e.status = nlt_pkg::ST_BUSY;
            end else if (op_e.status == nlt_pkg::ST_BUSY && op_e.active == 16'd0) begin
                op_e.status = nlt_pkg::ST_READY;
            end
        end
    end

    // Scan evaluation of the entry at r_idx.
    nlt_pkg::t_entry sc_e;
    logic [7:0]  miss_n;
    logic        cand, overdue, sc_write, found;
    logic [1:0]  sc_kind;
    always_comb begin
        sc_e    = rdata;
        miss_n  = (rdata.miss == 8'hFF) ? 8'hFF : rdata.miss + 8'd1;
        cand    = (CW'(r_idx) != CW'(r_own)) && (rdata.status != nlt_pkg::ST_DEAD) &&
                  rdata.seen;
        overdue = (r_now - rdata.seen_ms) > {8'd0, r_window};
        sc_write = 1'b0;
        found    = 1'b0;
        sc_kind  = nlt_pkg::KIND_RETRY;
        if (r_op == nlt_pkg::OP_TICK) begin
            sc_kind = nlt_pkg::KIND_DIED;
            if (cand && overdue) begin
                sc_write = 1'b1;
                sc_e.miss = miss_n;
                if (miss_n >= r_miss_limit) begin
                    found = 1'b1;
                    sc_e.status    = nlt_pkg::ST_DEAD;
                    sc_e.active    = 16'd0;
                    sc_e.pending   = 1'b1;
                    sc_e.dead_time = r_now;
                end else begin
                    sc_e.status = nlt_pkg::ST_DEGRADED;
                end
            end
        end else begin
            found = rdata.pending && ((r_now - rdata.dead_time) >= {8'd0, r_retry});
        end
    end

    nlt_pkg::t_result sc_res, op_res, none_res;
    assign sc_res = '{node: 6'(r_idx), kind: sc_kind, status: sc_e.status,
                      active: sc_e.active, miss: sc_e.miss, link: sc_e.link};
    assign op_res = '{node: 6'(r_node), kind: nlt_pkg::KIND_STATUS, status: op_e.status,
                      active: op_e.active, miss: op_e.miss, link: op_e.link};
    assign none_res = '{node: 6'd0, kind: nlt_pkg::KIND_NONE, status: nlt_pkg::ST_UNKNOWN,
                        active: 16'd0, miss: 8'd0, link: 1'b0};

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_out        = r_out;
        n_out_last   = r_out_last;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_hold       = r_hold;
        n_hold_valid = r_hold_valid;
        we    = 1'b0;
        waddr = r_idx;
        wdata = '0;
        re    = 1'b0;
        raddr = r_idx;
        case (r_state)
            S_CLEAR: begin
                we = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (is_scan) begin
                        re      = 1'b1;
                        raddr   = '0;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end else if (is_node_op) begin
                        re      = 1'b1;
                        raddr   = IW'(i_node_id);
                        n_state = S_OP;
                    end
                end
            end
            S_OP: begin
                if (out_free) begin
                    we          = 1'b1;
                    waddr       = r_node;
                    wdata       = op_e;
                    n_out       = op_res;
                    n_out_last  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_SCAN: begin
                if (!(found && r_hold_valid && !out_free)) begin
                    we    = sc_write;
                    wdata = sc_e;
                    if (found) begin
                        if (r_hold_valid) begin
                            n_out       = r_hold;
                            n_out_last  = 1'b0;
                            n_out_valid = 1'b1;
                        end
                        n_hold       = sc_res;
                        n_hold_valid = 1'b1;
                    end
                    if (r_idx == LAST_IDX) begin
                        n_state = S_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        re    = 1'b1;
                        raddr = r_idx + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out        = r_hold_valid ? r_hold : none_res;
                    n_out_last   = 1'b1;
                    n_out_valid  = 1'b1;
                    n_hold_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_out_valid  <= n_out_valid;
            r_hold_valid <= n_hold_valid;
        end
        r_out      <= n_out;
        r_out_last <= n_out_last;
        r_hold     <= n_hold;
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_node  = r_out.node;
    assign o_result_kind  = r_out.kind;
    assign o_node_status  = r_out.status;
    assign o_active_count = r_out.active;
    assign o_miss_count   = r_out.miss;
    assign o_link_flag    = r_out.link;
    assign o_last         = r_out_last;

endmodule

### verif/node_liveness_tracker_test.sv
// Self-checking testbench for node_liveness_tracker: a directed table of items, then
// random heartbeat, join, dead, add, tick and query items, checked against a predictor.
// Depends on nlt_pkg and the node_liveness_tracker RTL.
module node_liveness_tracker_test;

    typedef struct {
        logic [2:0]  op;
        logic [5:0]  node;
        logic [31:0] now;
        logic        has_pl;
        logic [15:0] rep;
        logic [15:0] delta;
        logic        chk;
        nlt_pkg::t_result res;
    } t_row;

    typedef struct {
        nlt_pkg::t_result res;
        logic    last;
    } t_expect;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_operation;
    logic [5:0]  i_node_id;
    logic [31:0] i_now_ms;
    logic        i_has_payload;
    logic [15:0] i_reported_active;
    logic signed [15:0] i_active_delta;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [5:0]  o_result_node;
    logic [1:0]  o_result_kind;
    logic [2:0]  o_node_status;
    logic [15:0] o_active_count;
    logic [7:0]  o_miss_count;
    logic        o_link_flag;
    logic        o_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;

    node_liveness_tracker u_dut (.*);

    logic [15:0] beat_ms;
    logic [7:0]  miss_lim;
    logic [23:0] retry_ms;
    logic [5:0]  own_id;
    nlt_pkg::t_entry tbl [64];

    t_expect     pending_results [$];
    int          fail_count;
    int          hold_cycles;
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic void queue_result(t_expect e);
        pending_results = {pending_results, e};
    endfunction

    function automatic nlt_pkg::t_result entry_result(int n, logic [1:0] kind);
        nlt_pkg::t_result r;
        r.node = n[5:0];
        r.kind = kind;
        r.status = tbl[n].status;
        r.active = tbl[n].active;
        r.miss = tbl[n].miss;
        r.link = tbl[n].link;
        return r;
    endfunction

    function automatic void settle_load(int n);
        if (tbl[n].status == nlt_pkg::ST_READY && tbl[n].active != 0) begin
            tbl[n].status = nlt_pkg::ST_BUSY;
        end else if (tbl[n].status == nlt_pkg::ST_BUSY && tbl[n].active == 0) begin
            tbl[n].status = nlt_pkg::ST_READY;
        end
    endfunction

    // Applies one item to the liveness table copy and queues its results.
    function automatic void predict_liveness(t_row it);
        logic [31:0] window;
        logic [31:0] iv;
        logic [31:0] ml;
        logic [16:0] sum;
        logic [15:0] sub;
        int          n;
        int          found;
        t_expect     e;
        found = 0;
        n = int'(it.node);
        if (it.op == nlt_pkg::OP_TICK || it.op == nlt_pkg::OP_QUERY) begin
            iv = (beat_ms < nlt_pkg::BEAT_FLOOR) ? 32'(nlt_pkg::BEAT_FLOOR) : 32'(beat_ms);
            ml = (miss_lim < 8'd1) ? 32'd1 : 32'(miss_lim);
            window = iv * ml;
            for (int i = 0; i < 64; i++) begin
                if (it.op == nlt_pkg::OP_TICK) begin
                    if (i != int'(own_id) && tbl[i].status != nlt_pkg::ST_DEAD && tbl[i].seen
                            && (it.now - tbl[i].seen_ms) > window) begin
                        if (tbl[i].miss != 8'hff) tbl[i].miss++;
                        if (tbl[i].miss >= miss_lim) begin
                            tbl[i].status = nlt_pkg::ST_DEAD;
                            tbl[i].active = '0;
                            tbl[i].pending = 1'b1;
                            tbl[i].dead_time = it.now;
                            e.res = entry_result(i, nlt_pkg::KIND_DIED);
                            e.last = 1'b0;
                            queue_result(e);
                            found++;
                        end else begin
                            tbl[i].status = nlt_pkg::ST_DEGRADED;
                        end
                    end
                end else if (tbl[i].pending
                        && (it.now - tbl[i].dead_time) >= 32'(retry_ms)) begin
                    e.res = entry_result(i, nlt_pkg::KIND_RETRY);
                    e.last = 1'b0;
                    queue_result(e);
                    found++;
                end
            end
            if (found == 0) begin
                e.res = '0;
                e.res.kind = nlt_pkg::KIND_NONE;
                e.last = 1'b1;
                queue_result(e);
            end else begin
                pending_results[$].last = 1'b1;
            end
            return;
        end
        case (it.op)
            nlt_pkg::OP_BEAT: begin
                tbl[n].seen_ms = it.now;
                tbl[n].seen = 1'b1;
                tbl[n].miss = '0;
                if (tbl[n].status != nlt_pkg::ST_BUSY) tbl[n].status = nlt_pkg::ST_READY;
                tbl[n].pending = 1'b0;
                if (it.has_pl) begin
                    tbl[n].active = it.rep;
                    settle_load(n);
                end
            end
            nlt_pkg::OP_JOIN: begin
                tbl[n].status = nlt_pkg::ST_READY;
                tbl[n].link = 1'b1;
                tbl[n].miss = '0;
                tbl[n].seen_ms = it.now;
                tbl[n].seen = 1'b1;
                tbl[n].pending = 1'b0;
            end
            nlt_pkg::OP_DEAD: begin
                tbl[n].status = nlt_pkg::ST_DEAD;
                tbl[n].link = 1'b0;
                tbl[n].active = '0;
                tbl[n].pending = 1'b1;
                tbl[n].dead_time = it.now;
            end
            nlt_pkg::OP_ADD: begin
                if (!it.delta[15]) begin
                    sum = {1'b0, tbl[n].active} + {1'b0, it.delta};
                    tbl[n].active = sum[16] ? 16'hffff : sum[15:0];
                end else begin
                    sub = -it.delta;
                    tbl[n].active = (it.delta == 16'h8000)
                        ? ((tbl[n].active > 16'h8000) ? tbl[n].active - 16'h8000 : '0)
                        : ((tbl[n].active > sub) ? tbl[n].active - sub : '0);
                end
                settle_load(n);
            end
            default: return;
        endcase
        e.res = entry_result(n, nlt_pkg::KIND_STATUS);
        e.last = 1'b1;
        queue_result(e);
    endfunction

    task automatic random_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) g = 0;
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic send_item(t_row it);
        i_operation <= it.op;
        i_node_id <= it.node;
        i_now_ms <= it.now;
        i_has_payload <= it.has_pl;
        i_reported_active <= it.rep;
        i_active_delta <= it.delta;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_liveness(it);
        if (it.chk && pending_results.size() > 0
                && pending_results[$].res != it.res) begin
            $error("directed row: expected %h predicted %h", it.res, pending_results[$].res);
            fail_count++;
        end
        if ($urandom_range(0, 2) == 0) random_gap();
    endtask

    task automatic write_reg(logic [1:0] idx, logic [23:0] val);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            nlt_pkg::CFG_BEAT: beat_ms = val[15:0];
            nlt_pkg::CFG_MISS: miss_lim = val[7:0];
            nlt_pkg::CFG_RETRY: retry_ms = val;
            default: own_id = val[5:0];
        endcase
        @(posedge i_clk);
    endtask

    task automatic drain();
        int guard;
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (140) @(posedge i_clk);
    endtask

    function automatic t_row mk(logic [2:0] op, logic [5:0] node, logic [31:0] now);
        t_row it;
        it.op = op;
        it.node = node;
        it.now = now;
        it.has_pl = 1'b0;
        it.rep = '0;
        it.delta = '0;
        it.chk = 1'b0;
        it.res = '0;
        return it;
    endfunction

    function automatic t_row random_item();
        t_row it;
        int   pick;
        pick = $urandom_range(0, 99);
        it = mk(nlt_pkg::OP_BEAT, 6'($urandom_range(0, 63)), clock_ms);
        if (pick < 30) it.op = nlt_pkg::OP_BEAT;
        else if (pick < 42) it.op = nlt_pkg::OP_JOIN;
        else if (pick < 50) it.op = nlt_pkg::OP_DEAD;
        else if (pick < 64) it.op = nlt_pkg::OP_ADD;
        else if (pick < 82) it.op = nlt_pkg::OP_TICK;
        else if (pick < 96) it.op = nlt_pkg::OP_QUERY;
        else it.op = 3'($urandom_range(6, 7));
        it.has_pl = 1'($urandom_range(0, 1));
        it.rep = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 5));
        it.delta = ($urandom_range(0, 3) == 0) ? 16'($urandom)
            : 16'($signed($urandom_range(0, 10)) - 5);
        if ($urandom_range(0, 19) == 0) it.now = $urandom;
        return it;
    endfunction

    // Result side: random stalls plus one long hold-off to fill the block.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 9) == 0) ? 1'b0
                    : ($urandom_range(0, 59) == 0 ? 1'b0 : 1'b1);
                if ($urandom_range(0, 199) == 0) hold_cycles = $urandom_range(10, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result node %0d kind %0d", o_result_node, o_result_kind);
                fail_count++;
            end else begin
                e = pending_results.pop_front();
                if (o_result_node !== e.res.node) begin
                    $error("result_node expected %0d actual %0d", e.res.node, o_result_node);
                    fail_count++;
                end
                if (o_result_kind !== e.res.kind) begin
                    $error("result_kind expected %0d actual %0d", e.res.kind, o_result_kind);
                    fail_count++;
                end
                if (o_node_status !== e.res.status) begin
                    $error("node_status expected %0d actual %0d", e.res.status, o_node_status);
                    fail_count++;
                end
                if (o_active_count !== e.res.active) begin
                    $error("active_count expected %0d actual %0d", e.res.active,
                        o_active_count);
                    fail_count++;
                end
                if (o_miss_count !== e.res.miss) begin
                    $error("miss_count expected %0d actual %0d", e.res.miss, o_miss_count);
                    fail_count++;
                end
                if (o_link_flag !== e.res.link) begin
                    $error("link_flag expected %0d actual %0d", e.res.link, o_link_flag);
                    fail_count++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        t_row rows [$];
        t_row it;
        nlt_pkg::t_result r;
        int guard;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = nlt_pkg::OP_TICK;
        i_node_id = '0;
        i_now_ms = '0;
        i_has_payload = 1'b0;
        i_reported_active = '0;
        i_active_delta = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = nlt_pkg::CFG_BEAT;
        i_cfg_data = '0;
        fail_count = 0;
        hold_cycles = 0;
        clock_ms = 32'd100;
        beat_ms = nlt_pkg::BEAT_RESET;
        miss_lim = nlt_pkg::MISS_RESET;
        retry_ms = nlt_pkg::RETRY_RESET;
        own_id = '0;
        for (int i = 0; i < 64; i++) tbl[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows; the ones with chk set carry a result read off by hand.
        r = '0;
        r.kind = nlt_pkg::KIND_NONE;
        it = mk(nlt_pkg::OP_TICK, 6'd0, 32'd0); it.chk = 1'b1; it.res = r; rows = {rows, it};
        it = mk(nlt_pkg::OP_QUERY, 6'd0, 32'd0); it.chk = 1'b1; it.res = r; rows = {rows, it};
        r = '0; r.node = 6'd63; r.status = nlt_pkg::ST_READY; r.link = 1'b1;
        it = mk(nlt_pkg::OP_JOIN, 6'd63, 32'hffff_ff00); it.chk = 1'b1; it.res = r;
        rows = {rows, it};
        it = mk(nlt_pkg::OP_BEAT, 6'd1, 32'd0); it.has_pl = 1'b1; it.rep = 16'hffff;
        rows = {rows, it};
        it = mk(nlt_pkg::OP_ADD, 6'd1, 32'd0); it.delta = 16'h7fff; rows = {rows, it};
        it = mk(nlt_pkg::OP_ADD, 6'd1, 32'd0); it.delta = 16'h8000; rows = {rows, it};
        it = mk(nlt_pkg::OP_ADD, 6'd1, 32'd0); it.delta = 16'h8000; rows = {rows, it};
        it = mk(nlt_pkg::OP_ADD, 6'd1, 32'd0); it.delta = 16'h8000; rows = {rows, it};
        it = mk(nlt_pkg::OP_BEAT, 6'd2, 32'd10); it.has_pl = 1'b1; it.rep = 16'd5;
        rows = {rows, it};
        it = mk(nlt_pkg::OP_BEAT, 6'd2, 32'd20); it.has_pl = 1'b1; it.rep = 16'd0;
        rows = {rows, it};
        r = '0; r.node = 6'd5; r.status = nlt_pkg::ST_DEAD;
        it = mk(nlt_pkg::OP_DEAD, 6'd5, 32'd100); it.chk = 1'b1; it.res = r;
        rows = {rows, it};
        it = mk(nlt_pkg::OP_TICK, 6'd0, 32'd3500); rows = {rows, it};
        it = mk(nlt_pkg::OP_TICK, 6'd0, 32'd7000); rows = {rows, it};
        it = mk(nlt_pkg::OP_TICK, 6'd0, 32'd12000); rows = {rows, it};
        it = mk(nlt_pkg::OP_QUERY, 6'd0, 32'd5100); rows = {rows, it};
        it = mk(nlt_pkg::OP_QUERY, 6'd0, 32'h1000_0000); rows = {rows, it};
        it = mk(3'd6, 6'd3, 32'd0); rows = {rows, it};
        it = mk(3'd7, 6'd3, 32'd0); rows = {rows, it};
        it = mk(nlt_pkg::OP_BEAT, 6'd63, 32'h0000_0050); it.has_pl = 1'b1;
        it.rep = 16'h5555;
        rows = {rows, it};
        it = mk(nlt_pkg::OP_ADD, 6'd63, 32'd0); it.delta = 16'haaaa; rows = {rows, it};
        it = mk(nlt_pkg::OP_BEAT, 6'd0, 32'd0); rows = {rows, it};
        it = mk(nlt_pkg::OP_TICK, 6'd0, 32'hffff_ffff); rows = {rows, it};
        foreach (rows[k]) send_item(rows[k]);
        drain();

        // Miss limit zero, short window, own node moved to the top of the table.
        write_reg(nlt_pkg::CFG_BEAT, 24'd0);
        write_reg(nlt_pkg::CFG_MISS, 24'd0);
        write_reg(nlt_pkg::CFG_RETRY, 24'd0);
        write_reg(nlt_pkg::CFG_OWN, 24'd63);
        for (int p = 0; p < 5; p++) begin
            for (int k = 0; k < 60; k++) begin
                clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 400) : 20;
                send_item(random_item());
            end
            if (p == 0) begin
                // Long hold-off while items keep coming, so the block backs up.
                hold_cycles = 600;
                for (int k = 0; k < 12; k++) send_item(mk(nlt_pkg::OP_TICK, 6'd0, clock_ms));
            end
            drain();
            case (p)
                0: begin
                    write_reg(nlt_pkg::CFG_BEAT, 24'hffff);
                    write_reg(nlt_pkg::CFG_MISS, 24'hff);
                    write_reg(nlt_pkg::CFG_RETRY, 24'hffffff);
                    write_reg(nlt_pkg::CFG_OWN, 24'd0);
                end
                1: begin
                    write_reg(nlt_pkg::CFG_BEAT, 24'd60);
                    write_reg(nlt_pkg::CFG_MISS, 24'd2);
                    write_reg(nlt_pkg::CFG_RETRY, 24'd300);
                    write_reg(nlt_pkg::CFG_OWN, 24'($urandom_range(0, 63)));
                end
                2: begin
                    write_reg(nlt_pkg::CFG_BEAT, 24'd49);
                    write_reg(nlt_pkg::CFG_MISS, 24'd1);
                    write_reg(nlt_pkg::CFG_RETRY, 24'd50);
                end
                default: begin
                    write_reg(nlt_pkg::CFG_BEAT, 24'd1000);
                    write_reg(nlt_pkg::CFG_MISS, 24'd3);
                    write_reg(nlt_pkg::CFG_RETRY, 24'd5000);
                    write_reg(nlt_pkg::CFG_OWN, 24'd17);
                end
            endcase
        end
        for (int k = 0; k < 80; k++) begin
            clock_ms += $urandom_range(0, 2) == 0 ? $urandom_range(0, 3000) : 300;
            send_item(random_item());
        end
        i_in_valid <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 500000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### sim.f
rtl/nlt_pkg.sv
rtl/nlt_table.sv
rtl/node_liveness_tracker.sv
verif/node_liveness_tracker_test.sv
